FILE: hw/rtl/bmcc_pkg.sv
// Package for the battery mode and contactor controller.
// Mode encoding, register indexes, fault masks and flag positions.
// No dependencies.
package bmcc_pkg;

  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModePre   = 3'd1,
    ModeDis   = 3'd2,
    ModeChg   = 3'd3,
    ModeHeat  = 3'd4,
    ModeCool  = 3'd5,
    ModeProt  = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    CfgPrechargeTicks   = 3'd0,
    CfgDelayShort       = 3'd1,
    CfgDelayLong        = 3'd2,
    CfgDischargeCool    = 3'd3,
    CfgChargeCool       = 3'd4,
    CfgChargeHeat       = 3'd5
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned FlagsW   = 5;

  localparam logic [11:0] IdleWarnSet = 12'hCBE;
  localparam logic [11:0] RunWarnSet  = 12'h3FF;
  localparam logic [7:0]  SevereErr   = 8'h07;
  localparam logic [6:0]  SocFull     = 7'd99;
  localparam logic [6:0]  SocLimit    = 7'd100;
  localparam logic signed [8:0] CoolMargin = 9'sd5;

  localparam int unsigned FlgPre  = 0;
  localparam int unsigned FlgPos  = 1;
  localparam int unsigned FlgNeg  = 2;
  localparam int unsigned FlgCool = 3;
  localparam int unsigned FlgHeat = 4;

endpackage

FILE: hw/rtl/battery_mode_contactor_controller.sv
// Battery pack mode controller and contactor driver, top level.
// Uses bmcc_pkg for mode codes, register indexes and fault masks.
//
//   channel | direction | handshake               | contents
//   in      | sink      | in_valid_i / in_ready_o | one tick word (mode or relay)
//   out     | source    | out_valid_o/out_ready_i | mode and five contactor flags
//   cfg     | sink      | cfg_we_i                | register index and write data
//
// A result passes an input register, then one pass of compares and a counter update
// into the state registers, which also form the result register. One word per cycle
// is sustained while out_ready_i is high.
// rst_ni clears the mode, counters, flags and valids and loads register defaults.
// A stalled result holds the state; the input register still takes one word.
module battery_mode_contactor_controller
  import bmcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [11:0]         warn_mask_i,
  input  logic [7:0]          error_bits_i,
  input  logic                charger_present_i,
  input  logic [6:0]          soc_percent_i,
  input  logic                discharge_done_i,
  input  logic                charge_done_i,
  input  logic signed [7:0]   temp_min_i,
  input  logic signed [7:0]   temp_max_i,
  input  logic signed [7:0]   temp_avg_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          mode_o,
  output logic                precharge_on_o,
  output logic                positive_on_o,
  output logic                negative_on_o,
  output logic                cooling_on_o,
  output logic                heating_on_o,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // configuration registers
  logic [CountW-1:0] pre_ticks_q, delay_short_q, delay_long_q;
  logic signed [7:0] dis_cool_q, chg_cool_q, chg_heat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_ticks_q   <= 16'd50;
      delay_short_q <= 16'd100;
      delay_long_q  <= 16'd2000;
      dis_cool_q    <= 8'sd45;
      chg_cool_q    <= 8'sd40;
      chg_heat_q    <= 8'sd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPrechargeTicks: pre_ticks_q   <= cfg_wdata_i;
        CfgDelayShort:     delay_short_q <= cfg_wdata_i;
        CfgDelayLong:      delay_long_q  <= cfg_wdata_i;
        CfgDischargeCool:  dis_cool_q    <= $signed(cfg_wdata_i[7:0]);
        CfgChargeCool:     chg_cool_q    <= $signed(cfg_wdata_i[7:0]);
        CfgChargeHeat:     chg_heat_q    <= $signed(cfg_wdata_i[7:0]);
        default: ;
      endcase
    end
  end

  // input register
  logic              in_vld_q;
  logic              kind_q;
  logic [11:0]       warn_q;
  logic [7:0]        err_q;
  logic              chg_q;
  logic [6:0]        soc_q;
  logic              dis_done_q;
  logic              chg_done_q;
  logic signed [7:0] tmin_q, tmax_q, tavg_q;

  logic out_vld_q;
  logic advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q     <= kind_i;
      warn_q     <= warn_mask_i;
      err_q      <= error_bits_i;
      chg_q      <= charger_present_i;
      soc_q      <= soc_percent_i;
      dis_done_q <= discharge_done_i;
      chg_done_q <= charge_done_i;
      tmin_q     <= temp_min_i;
      tmax_q     <= temp_max_i;
      tavg_q     <= temp_avg_i;
    end
  end

  // state, doubling as the result register
  mode_e             mode_q, mode_d;
  logic [CountW-1:0] pre_cnt_q, pre_cnt_d;
  logic [CountW-1:0] prot_cnt_q, prot_cnt_d;
  logic [FlagsW-1:0] flags_q, flags_d;

  logic              run_fault, idle_fault, prot_hold;
  logic [CountW-1:0] pre_cnt_inc;
  logic signed [8:0] cool_lim;
  logic              need_cool;

  assign run_fault   = (|(warn_q & RunWarnSet)) || (|(err_q & SevereErr));
  assign idle_fault  = (|(warn_q & IdleWarnSet)) || (|(err_q & SevereErr));
  assign prot_hold   = (|(warn_q & RunWarnSet)) || (|err_q);
  assign pre_cnt_inc = (&pre_cnt_q) ? pre_cnt_q : pre_cnt_q + 16'd1;
  assign cool_lim    = $signed({dis_cool_q[7], dis_cool_q}) - CoolMargin;
  assign need_cool   = $signed({tavg_q[7], tavg_q}) >= cool_lim;

  always_comb begin
    mode_d     = mode_q;
    pre_cnt_d  = pre_cnt_q;
    prot_cnt_d = prot_cnt_q;
    flags_d    = flags_q;
    if (advance && !kind_q) begin
      case (mode_q)
        ModeIdle: begin
          if (idle_fault) begin
            mode_d = ModeProt;
          end else if (chg_q && soc_q < SocLimit) begin
            mode_d = ModeChg;
          end else begin
            mode_d    = ModePre;
            pre_cnt_d = '0;
          end
        end
        ModePre: begin
          if (run_fault) begin
            mode_d = ModeProt;
          end else if (pre_cnt_inc > pre_ticks_q) begin
            mode_d    = ModeDis;
            pre_cnt_d = '0;
          end else begin
            pre_cnt_d = pre_cnt_inc;
          end
        end
        ModeDis: begin
          if (run_fault) begin
            mode_d = ModeProt;
          end else if (chg_q) begin
            mode_d     = ModeProt;
            prot_cnt_d = delay_short_q;
          end else if (dis_done_q) begin
            mode_d     = ModeProt;
            prot_cnt_d = delay_long_q;
          end
        end
        ModeChg: begin
          if (run_fault) mode_d = ModeProt;
          else if (!chg_q) mode_d = ModeIdle;
        end
        ModeHeat: begin
          if (run_fault) mode_d = ModeProt;
          else if (tmin_q > chg_heat_q) mode_d = chg_q ? ModeChg : ModeIdle;
        end
        ModeCool: begin
          if (run_fault) mode_d = ModeProt;
          else if (tmax_q < chg_cool_q && chg_q) mode_d = ModeChg;
          else if (tmax_q < dis_cool_q && !chg_q) mode_d = ModeIdle;
        end
        ModeProt: begin
          if (!prot_hold) begin
            if (chg_q) begin
              if (!chg_done_q) mode_d = ModeChg;
            end else if (soc_q != 7'd0) begin
              mode_d = ModeIdle;
            end
          end
        end
        default: ;
      endcase
    end else if (advance) begin
      case (mode_q)
        ModeIdle: begin
          flags_d[FlgPre]  = 1'b0;
          flags_d[FlgPos]  = 1'b0;
          flags_d[FlgNeg]  = 1'b0;
          flags_d[FlgCool] = 1'b0;
        end
        ModePre: begin
          flags_d[FlgPos] = 1'b0;
          flags_d[FlgNeg] = 1'b1;
          flags_d[FlgPre] = 1'b1;
        end
        ModeDis: begin
          flags_d[FlgCool] = need_cool;
          flags_d[FlgPre]  = 1'b0;
          flags_d[FlgPos]  = 1'b1;
          flags_d[FlgNeg]  = 1'b1;
        end
        ModeChg: begin
          flags_d[FlgPre] = 1'b0;
          flags_d[FlgPos] = !(soc_q > SocFull);
          flags_d[FlgNeg] = !(soc_q > SocFull);
        end
        ModeHeat: begin
          flags_d          = '0;
          flags_d[FlgHeat] = 1'b1;
        end
        ModeCool: begin
          flags_d          = '0;
          flags_d[FlgCool] = 1'b1;
        end
        ModeProt: begin
          flags_d[FlgPre] = 1'b0;
          if (prot_cnt_q == '0) begin
            flags_d[FlgPos] = 1'b0;
            flags_d[FlgNeg] = 1'b0;
          end else begin
            prot_cnt_d = prot_cnt_q - 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeIdle;
      pre_cnt_q  <= '0;
      prot_cnt_q <= '0;
      flags_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      pre_cnt_q  <= pre_cnt_d;
      prot_cnt_q <= prot_cnt_d;
      flags_q    <= flags_d;
      out_vld_q  <= advance || (out_vld_q && !out_ready_i);
    end
  end

  assign out_valid_o    = out_vld_q;
  assign mode_o         = mode_q;
  assign precharge_on_o = flags_q[FlgPre];
  assign positive_on_o  = flags_q[FlgPos];
  assign negative_on_o  = flags_q[FlgNeg];
  assign cooling_on_o   = flags_q[FlgCool];
  assign heating_on_o   = flags_q[FlgHeat];

  // checks
  a_relay_keeps_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && kind_q) |=> (mode_q == $past(mode_q)))
    else $error("relay tick changed the mode");

  a_mode_keeps_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !kind_q) |=> (flags_q == $past(flags_q)))
    else $error("mode tick changed the contactor flags");

  a_prot_countdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && kind_q && mode_q == ModeProt && prot_cnt_q != '0)
    |=> (prot_cnt_q == $past(prot_cnt_q) - 16'd1) && flags_q[FlgPos] == $past(flags_q[FlgPos]))
    else $error("protection countdown did not step");

  a_no_invented_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_ready_i && !advance) |=> !out_vld_q)
    else $error("result shown without a new word");

endmodule

FILE: tb/battery_mode_contactor_controller_test.sv
// Testbench for battery_mode_contactor_controller: directed and random tick words,
// checked word by word against an in-bench prediction of mode and contactor flags.
// Depends on bmcc_pkg and the controller RTL only.
`timescale 1ns / 100ps

module battery_mode_contactor_controller_test;
  import bmcc_pkg::*;

  typedef struct {
    logic              kind;
    logic [11:0]       warn;
    logic [7:0]        err;
    logic              chg;
    logic [6:0]        soc;
    logic              dis_done;
    logic              chg_done;
    logic signed [7:0] tmin;
    logic signed [7:0] tmax;
    logic signed [7:0] tavg;
  } tick_t;

  typedef struct {
    mode_e mode;
    logic  pre;
    logic  pos;
    logic  neg;
    logic  cool;
    logic  heat;
  } pack_status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                kind_i = 1'b0;
  logic [11:0]         warn_mask_i = '0;
  logic [7:0]          error_bits_i = '0;
  logic                charger_present_i = 1'b0;
  logic [6:0]          soc_percent_i = '0;
  logic                discharge_done_i = 1'b0;
  logic                charge_done_i = 1'b0;
  logic signed [7:0]   temp_min_i = '0;
  logic signed [7:0]   temp_max_i = '0;
  logic signed [7:0]   temp_avg_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [2:0]          mode_o;
  logic                precharge_on_o;
  logic                positive_on_o;
  logic                negative_on_o;
  logic                cooling_on_o;
  logic                heating_on_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // predicted pack state and register copies
  mode_e             pred_mode = ModeIdle;
  logic [15:0]       pred_pre_count = '0;
  logic [15:0]       pred_countdown = '0;
  logic [4:0]        pred_flags = '0;
  logic [15:0]       pred_pre_ticks = 16'd50;
  logic [15:0]       pred_dly_short = 16'd100;
  logic [15:0]       pred_dly_long = 16'd2000;
  logic signed [7:0] pred_dis_cool = 8'sd45;
  logic signed [7:0] pred_chg_cool = 8'sd40;
  logic signed [7:0] pred_chg_heat = 8'sd0;

  pack_status_t pending_status[$];
  int mismatches = 0;
  int results_seen = 0;
  int tx_idle_pct = 31;
  int rx_idle_pct = 31;

  battery_mode_contactor_controller DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .kind_i            (kind_i),
    .warn_mask_i       (warn_mask_i),
    .error_bits_i      (error_bits_i),
    .charger_present_i (charger_present_i),
    .soc_percent_i     (soc_percent_i),
    .discharge_done_i  (discharge_done_i),
    .charge_done_i     (charge_done_i),
    .temp_min_i        (temp_min_i),
    .temp_max_i        (temp_max_i),
    .temp_avg_i        (temp_avg_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .mode_o            (mode_o),
    .precharge_on_o    (precharge_on_o),
    .positive_on_o     (positive_on_o),
    .negative_on_o     (negative_on_o),
    .cooling_on_o      (cooling_on_o),
    .heating_on_o      (heating_on_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic pack_status_t predict_pack_tick(input tick_t w);
    logic         run_fault;
    logic [4:0]   f;
    pack_status_t s;
    run_fault = (|(w.warn & RunWarnSet)) || (|(w.err & SevereErr));
    if (!w.kind) begin
      case (pred_mode)
        ModeIdle: begin
          if ((|(w.warn & IdleWarnSet)) || (|(w.err & SevereErr))) begin
            pred_mode = ModeProt;
          end else if (w.chg && w.soc < SocLimit) begin
            pred_mode = ModeChg;
          end else begin
            pred_mode = ModePre;
            pred_pre_count = '0;
          end
        end
        ModePre: begin
          if (run_fault) begin
            pred_mode = ModeProt;
          end else begin
            if (pred_pre_count != 16'hFFFF) pred_pre_count = pred_pre_count + 16'd1;
            if (pred_pre_count > pred_pre_ticks) begin
              pred_mode = ModeDis;
              pred_pre_count = '0;
            end
          end
        end
        ModeDis: begin
          if (run_fault) begin
            pred_mode = ModeProt;
          end else begin
            if (w.dis_done) begin
              pred_mode = ModeProt;
              pred_countdown = pred_dly_long;
            end
            if (w.chg) begin
              pred_mode = ModeProt;
              pred_countdown = pred_dly_short;
            end
          end
        end
        ModeChg: begin
          if (run_fault) pred_mode = ModeProt;
          else if (!w.chg) pred_mode = ModeIdle;
        end
        ModeHeat: begin
          if (run_fault) pred_mode = ModeProt;
          else if (w.tmin > pred_chg_heat) pred_mode = w.chg ? ModeChg : ModeIdle;
        end
        ModeCool: begin
          if (run_fault) pred_mode = ModeProt;
          else if (w.tmax < pred_chg_cool && w.chg) pred_mode = ModeChg;
          else if (w.tmax < pred_dis_cool && !w.chg) pred_mode = ModeIdle;
        end
        ModeProt: begin
          if ((|(w.warn & RunWarnSet)) || (|w.err)) begin
            pred_mode = ModeProt;
          end else if (w.chg) begin
            if (!w.chg_done) pred_mode = ModeChg;
          end else if (w.soc != 0) begin
            pred_mode = ModeIdle;
          end
        end
        default: ;
      endcase
    end else begin
      f = pred_flags;
      case (pred_mode)
        ModeIdle: begin
          f[FlgPre] = 1'b0;
          f[FlgPos] = 1'b0;
          f[FlgNeg] = 1'b0;
          f[FlgCool] = 1'b0;
        end
        ModePre: begin
          f[FlgPos] = 1'b0;
          f[FlgNeg] = 1'b1;
          f[FlgPre] = 1'b1;
        end
        ModeDis: begin
          f[FlgCool] = (int'(w.tavg) >= int'(pred_dis_cool) - int'(CoolMargin));
          f[FlgPre] = 1'b0;
          f[FlgPos] = 1'b1;
          f[FlgNeg] = 1'b1;
        end
        ModeChg: begin
          f[FlgPre] = 1'b0;
          f[FlgPos] = !(w.soc > SocFull);
          f[FlgNeg] = !(w.soc > SocFull);
        end
        ModeHeat: begin
          f = '0;
          f[FlgHeat] = 1'b1;
        end
        ModeCool: begin
          f = '0;
          f[FlgCool] = 1'b1;
        end
        ModeProt: begin
          f[FlgPre] = 1'b0;
          if (pred_countdown == 0) begin
            f[FlgPos] = 1'b0;
            f[FlgNeg] = 1'b0;
          end else begin
            pred_countdown = pred_countdown - 16'd1;
          end
        end
        default: ;
      endcase
      pred_flags = f;
    end
    s.mode = pred_mode;
    s.pre  = pred_flags[FlgPre];
    s.pos  = pred_flags[FlgPos];
    s.neg  = pred_flags[FlgNeg];
    s.cool = pred_flags[FlgCool];
    s.heat = pred_flags[FlgHeat];
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < 50) begin
      $display("[%0t] result %0d %s: got %0d, want %0d", $time, results_seen, what, got, want);
    end
    mismatches++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk_i) begin : check_results
    pack_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_status.size() == 0) begin
        report_mismatch("unexpected word, mode", mode_o, 0);
      end else begin
        want = pending_status.pop_front();
        if (mode_o !== want.mode) report_mismatch("mode", mode_o, want.mode);
        if (precharge_on_o !== want.pre) report_mismatch("precharge_on", precharge_on_o, want.pre);
        if (positive_on_o !== want.pos) report_mismatch("positive_on", positive_on_o, want.pos);
        if (negative_on_o !== want.neg) report_mismatch("negative_on", negative_on_o, want.neg);
        if (cooling_on_o !== want.cool) report_mismatch("cooling_on", cooling_on_o, want.cool);
        if (heating_on_o !== want.heat) report_mismatch("heating_on", heating_on_o, want.heat);
      end
      results_seen++;
    end
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // leaves valid high on return; the next call or wait_drained decides
  task automatic offer_tick(input tick_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    kind_i            <= w.kind;
    warn_mask_i       <= w.warn;
    error_bits_i      <= w.err;
    charger_present_i <= w.chg;
    soc_percent_i     <= w.soc;
    discharge_done_i  <= w.dis_done;
    charge_done_i     <= w.chg_done;
    temp_min_i        <= w.tmin;
    temp_max_i        <= w.tmax;
    temp_avg_i        <= w.tavg;
    do @(posedge clk_i); while (!in_ready_o);
    pending_status.push_back(predict_pack_tick(w));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_status.size() != 0);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgPrechargeTicks: pred_pre_ticks = value;
      CfgDelayShort:     pred_dly_short = value;
      CfgDelayLong:      pred_dly_long = value;
      CfgDischargeCool:  pred_dis_cool = value[7:0];
      CfgChargeCool:     pred_chg_cool = value[7:0];
      CfgChargeHeat:     pred_chg_heat = value[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all_registers(input logic [15:0] ticks, input logic [15:0] dly_s,
                                     input logic [15:0] dly_l, input logic signed [7:0] dc,
                                     input logic signed [7:0] cc, input logic signed [7:0] ch);
    wait_drained();
    write_register(CfgPrechargeTicks, ticks);
    write_register(CfgDelayShort, dly_s);
    write_register(CfgDelayLong, dly_l);
    write_register(CfgDischargeCool, {{8{dc[7]}}, dc});
    write_register(CfgChargeCool, {{8{cc[7]}}, cc});
    write_register(CfgChargeHeat, {{8{ch[7]}}, ch});
  endtask

  function automatic tick_t quiet_tick(input logic kind);
    tick_t t;
    t.kind = kind;
    t.warn = '0;
    t.err = '0;
    t.chg = 1'b0;
    t.soc = 7'd50;
    t.dis_done = 1'b0;
    t.chg_done = 1'b0;
    t.tmin = 8'sd20;
    t.tmax = 8'sd25;
    t.tavg = 8'sd22;
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t       t;
    logic [31:0] bits;
    int          roll;
    bits = $urandom;
    t.kind = bits[0];
    t.chg_done = bits[1];
    t.tmin = bits[15:8];
    t.tmax = bits[23:16];
    t.tavg = bits[31:24];
    t.chg = ($urandom_range(0, 99) < 35);
    t.dis_done = ($urandom_range(0, 99) < 15);
    roll = $urandom_range(0, 99);
    if (roll < 8) t.warn = 12'($urandom_range(0, 4095));
    else if (roll < 16) t.warn = 12'd1 << $urandom_range(0, 11);
    else t.warn = '0;
    roll = $urandom_range(0, 99);
    if (roll < 6) t.err = 8'($urandom_range(0, 255));
    else if (roll < 12) t.err = 8'd1 << $urandom_range(0, 7);
    else t.err = '0;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      t.soc = 7'($urandom_range(101, 127));
    end else if (roll < 22) begin
      case ($urandom_range(0, 2))
        0: t.soc = 7'd0;
        1: t.soc = 7'd99;
        default: t.soc = 7'd100;
      endcase
    end else begin
      t.soc = 7'($urandom_range(0, 100));
    end
    return t;
  endfunction

  function automatic logic [15:0] random_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 16'($urandom_range(0, 6));
    if (roll < 85) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic steer_to_idle();
    tick_t t;
    while (pred_mode != ModeIdle) begin
      t = quiet_tick(1'b0);
      if (pred_mode != ModeProt && pred_mode != ModeChg) t.err = SevereErr;
      offer_tick(t);
    end
  endtask

  // idle exits, charge contactors, short discharge exit, protection hold and exits
  task automatic test_idle_and_charge();
    tick_t t;
    write_all_registers(16'd1, 16'd2, 16'hFFFF, 8'sh80, 8'sh7F, 8'sh7F);
    offer_tick(quiet_tick(1'b1));
    t = quiet_tick(1'b0); t.warn = 12'h001; t.chg = 1'b1; t.soc = 7'd99; offer_tick(t);
    t = quiet_tick(1'b1); t.soc = 7'd99; offer_tick(t);
    t = quiet_tick(1'b1); t.soc = 7'd100; offer_tick(t);
    t = quiet_tick(1'b0); t.warn = 12'h400; offer_tick(t);
    t = quiet_tick(1'b0); t.chg = 1'b1; t.soc = 7'd100; offer_tick(t);
    offer_tick(quiet_tick(1'b1));
    offer_tick(quiet_tick(1'b0));
    offer_tick(quiet_tick(1'b0));
    t = quiet_tick(1'b1); t.tavg = 8'sh80; offer_tick(t);
    t = quiet_tick(1'b0); t.dis_done = 1'b1; t.chg = 1'b1; offer_tick(t);
    repeat (3) offer_tick(quiet_tick(1'b1));
    t = quiet_tick(1'b0); t.err = 8'h80; offer_tick(t);
    t = quiet_tick(1'b0); t.warn = 12'h800; t.chg = 1'b1; t.chg_done = 1'b1; offer_tick(t);
    t = quiet_tick(1'b0); t.chg = 1'b1; offer_tick(t);
    t = quiet_tick(1'b0); t.err = 8'h01; offer_tick(t);
    t = quiet_tick(1'b0); t.soc = 7'd0; offer_tick(t);
    t = quiet_tick(1'b0); t.soc = 7'd127; offer_tick(t);
    t = quiet_tick(1'b0); t.warn = 12'hFFF; t.tmin = 8'sh7F; t.tmax = 8'sh80; offer_tick(t);
    wait_drained();
  endtask

  // long discharge exit, cooling threshold edge, faults in precharge, discharge and charge
  task automatic test_discharge_and_faults();
    tick_t t;
    write_all_registers(16'd0, 16'd1, 16'd3, 8'sh7F, 8'sd0, 8'sd0);
    steer_to_idle();
    offer_tick(quiet_tick(1'b0));
    offer_tick(quiet_tick(1'b1));
    offer_tick(quiet_tick(1'b0));
    t = quiet_tick(1'b1); t.tavg = 8'sd122; offer_tick(t);
    t = quiet_tick(1'b1); t.tavg = 8'sd121; offer_tick(t);
    t = quiet_tick(1'b0); t.dis_done = 1'b1; offer_tick(t);
    repeat (4) offer_tick(quiet_tick(1'b1));
    t = quiet_tick(1'b0); t.soc = 7'd1; offer_tick(t);
    offer_tick(quiet_tick(1'b0));
    t = quiet_tick(1'b0); t.warn = 12'h200; offer_tick(t);
    t = quiet_tick(1'b0); t.err = 8'h08; offer_tick(t);
    offer_tick(quiet_tick(1'b0));
    offer_tick(quiet_tick(1'b0));
    offer_tick(quiet_tick(1'b0));
    t = quiet_tick(1'b0); t.err = 8'h04; offer_tick(t);
    t = quiet_tick(1'b0); t.chg = 1'b1; offer_tick(t);
    t = quiet_tick(1'b0); t.warn = 12'h100; t.chg = 1'b1; offer_tick(t);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    for (int set_no = 0; set_no < 3; set_no++) begin
      case (set_no)
        0: write_all_registers(16'd0, 16'd0, 16'd0, 8'sh80, 8'sh80, 8'sh80);
        1: write_all_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'sh7F, 8'sh7F, 8'sh7F);
        default: write_all_registers(16'd3, 16'd4, 16'd9, 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      steer_to_idle();
      repeat (150) offer_tick(random_tick());
    end
    wait_drained();
  endtask

  // long precharge under the largest limit, then a lower limit ends it; no idling
  task automatic test_precharge_saturation();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_all_registers(16'hFFFF, 16'd5, 16'd5, 8'sd45, 8'sd40, 8'sd0);
    steer_to_idle();
    offer_tick(quiet_tick(1'b0));
    repeat (150) offer_tick(quiet_tick(1'b0));
    wait_drained();
    write_register(CfgPrechargeTicks, 16'd100);
    offer_tick(quiet_tick(1'b0));
    offer_tick(quiet_tick(1'b1));
    wait_drained();
    tx_idle_pct = 31;
    rx_idle_pct = 31;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      write_all_registers(random_span(), random_span(), random_span(),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
      for (int n = 0; n < 200; n++) begin
        if (phase == 1 && n == 100) wait_drained();
        offer_tick(random_tick());
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_and_charge();
    test_discharge_and_faults();
    test_register_extremes();
    test_precharge_saturation();
    test_random_traffic();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bmcc_pkg.sv
hw/rtl/battery_mode_contactor_controller.sv
tb/battery_mode_contactor_controller_test.sv
